[hw/rtl/atrlc_pkg.sv]
// shared types, constants and pattern tables of the response line classifier
package atrlc_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int COUNT_W       = $clog2(LINE_CAPACITY);
  localparam int NUM_PATTERNS  = 7;
  localparam int NUM_EXACT     = 4;
  localparam int LEN_W         = 7;
  localparam int LEN_MAX       = 127;
  localparam int PAT_CHARS     = 12;

  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_PROMPT = 8'h3E;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_OK     = 3'd1,
    EV_ERROR  = 3'd2,
    EV_BUSY   = 3'd3,
    EV_READY  = 3'd4,
    EV_PROMPT = 3'd5,
    EV_URC    = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    URC_NONE    = 2'd0,
    URC_CONN    = 2'd1,
    URC_DISCONN = 2'd2,
    URC_WRITE   = 2'd3
  } urc_kind_t;

  typedef struct packed {
    logic [COUNT_W-1:0]      count;
    logic [NUM_PATTERNS-1:0] alive;
  } line_state_t;

  typedef struct packed {
    event_t          event_code;
    urc_kind_t       urc_kind;
    logic [LEN_W-1:0] line_length;
  } result_t;

  // pattern text, left aligned, zero padded to twelve characters
  function automatic logic [8*PAT_CHARS-1:0] pat_text(input logic [2:0] idx);
    logic [8*PAT_CHARS-1:0] t;
    case (idx)
      3'd0:    t = {"OK\r\n", 64'h0};
      3'd1:    t = {"ERROR\r\n", 40'h0};
      3'd2:    t = {"busy p...\r\n", 8'h0};
      3'd3:    t = {"ready\r\n", 40'h0};
      3'd4:    t = {"+BLECONN:", 24'h0};
      3'd5:    t = "+BLEDISCONN:";
      3'd6:    t = {"+WRITE:", 40'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] pat_len(input logic [2:0] idx);
    logic [3:0] n;
    case (idx)
      3'd0:    n = 4'd4;
      3'd1:    n = 4'd7;
      3'd2:    n = 4'd11;
      3'd3:    n = 4'd7;
      3'd4:    n = 4'd9;
      3'd5:    n = 4'd12;
      3'd6:    n = 4'd7;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pat_char(input logic [2:0] idx, input logic [3:0] pos);
    logic [8*PAT_CHARS-1:0] t;
    logic [6:0]             msb;
    t   = pat_text(idx);
    msb = 7'(8*PAT_CHARS-1) - {pos, 3'b000};
    return t[msb -: 8];
  endfunction

endpackage

[hw/rtl/atrlc_ifs.sv]
// word channels of the response line classifier
interface atrlc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atrlc_ev_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [1:0] urc_kind;
  logic [6:0] line_length;
  modport source (output valid, output event_code, output urc_kind, output line_length,
                  input ready);
  modport sink   (input valid, input event_code, input urc_kind, input line_length,
                  output ready);
endinterface

interface atrlc_cfg_if;
  logic valid;
  logic ready;
  logic urc_enable;
  modport source (output valid, output urc_enable, input ready);
  modport sink   (input valid, input urc_enable, output ready);
endinterface

[hw/rtl/atrlc_step.sv]
// per-byte pattern tracking and line classification
module atrlc_step (
  input  atrlc_pkg::line_state_t st,
  input  logic [7:0]             rx_byte,
  input  logic                   urc_enable,
  output atrlc_pkg::line_state_t st_next,
  output atrlc_pkg::result_t     res
);

  logic                                stored;
  logic [atrlc_pkg::COUNT_W-1:0]       count_inc;
  logic [atrlc_pkg::NUM_PATTERNS-1:0]  alive_trk;
  logic [atrlc_pkg::COUNT_W-1:0]       plen;
  logic                                is_prompt;
  logic                                is_nl;
  logic                                sat;
  atrlc_pkg::event_t                   exact_ev;
  atrlc_pkg::urc_kind_t                urc_hit;

  assign stored = st.count < atrlc_pkg::COUNT_W'(atrlc_pkg::LINE_CAPACITY - 1);

  always_comb begin
    plen = '0;
    for (int i = 0; i < atrlc_pkg::NUM_PATTERNS; i++) begin
      plen = atrlc_pkg::COUNT_W'(atrlc_pkg::pat_len(3'(i)));
      if (!stored) begin
        alive_trk[i] = st.alive[i];
      end else if (st.count < plen) begin
        alive_trk[i] = st.alive[i] &&
                       (atrlc_pkg::pat_char(3'(i), st.count[3:0]) == rx_byte);
      end else begin
        alive_trk[i] = st.alive[i] && (i >= atrlc_pkg::NUM_EXACT);
      end
    end
  end

  assign count_inc = stored ? st.count + 1'b1 : st.count;
  assign is_prompt = (rx_byte == atrlc_pkg::CHAR_PROMPT) && (st.count == '0);
  assign is_nl     = rx_byte == atrlc_pkg::CHAR_NL;
  assign sat       = (atrlc_pkg::COUNT_W > atrlc_pkg::LEN_W) &&
                     (count_inc > atrlc_pkg::COUNT_W'(atrlc_pkg::LEN_MAX));

  // lowest index wins in both searches
  always_comb begin
    exact_ev = atrlc_pkg::EV_NONE;
    urc_hit  = atrlc_pkg::URC_NONE;
    for (int i = atrlc_pkg::NUM_EXACT - 1; i >= 0; i--) begin
      if (alive_trk[i] &&
          count_inc == atrlc_pkg::COUNT_W'(atrlc_pkg::pat_len(3'(i)))) begin
        exact_ev = atrlc_pkg::event_t'(3'(i + 1));
      end
    end
    for (int i = atrlc_pkg::NUM_PATTERNS - 1; i >= atrlc_pkg::NUM_EXACT; i--) begin
      if (alive_trk[i] &&
          count_inc >= atrlc_pkg::COUNT_W'(atrlc_pkg::pat_len(3'(i)))) begin
        urc_hit = atrlc_pkg::urc_kind_t'(2'(i - atrlc_pkg::NUM_EXACT + 1));
      end
    end
  end

  always_comb begin
    res.event_code  = atrlc_pkg::EV_NONE;
    res.urc_kind    = atrlc_pkg::URC_NONE;
    res.line_length = '0;
    st_next.count   = count_inc;
    st_next.alive   = alive_trk;
    if (is_prompt) begin
      res.event_code = atrlc_pkg::EV_PROMPT;
      st_next.count  = '0;
      st_next.alive  = '1;
    end else if (is_nl) begin
      res.line_length = sat ? atrlc_pkg::LEN_W'(atrlc_pkg::LEN_MAX)
                            : atrlc_pkg::LEN_W'(count_inc);
      if (exact_ev != atrlc_pkg::EV_NONE) begin
        res.event_code = exact_ev;
      end else if (urc_enable && urc_hit != atrlc_pkg::URC_NONE) begin
        res.event_code = atrlc_pkg::EV_URC;
        res.urc_kind   = urc_hit;
      end
      st_next.count = '0;
      st_next.alive = '1;
    end
  end

endmodule

[hw/rtl/at_response_line_classifier_unit.sv]
// top level of the response line classifier
// the result word of an accepted byte is registered into the output register in the next cycle
// throughput: one byte per cycle unless a full output register is stalled
// a new byte is taken whenever the output register is empty or being drained
// reset clears the line count, sets all match flags, disables urc reporting
// and empties the output register
module at_response_line_classifier_unit (
  input logic        clk,
  input logic        rst,
  atrlc_rx_if.sink   rx,
  atrlc_ev_if.source ev,
  atrlc_cfg_if.sink  cfg
);

  atrlc_pkg::line_state_t st;
  atrlc_pkg::line_state_t st_next;
  atrlc_pkg::result_t     res;
  atrlc_pkg::result_t     out_word;
  logic                   out_valid;
  logic                   urc_en;
  logic                   take;

  atrlc_step u_step (
    .st         (st),
    .rx_byte    (rx.rx_byte),
    .urc_enable (urc_en),
    .st_next    (st_next),
    .res        (res)
  );

  assign rx.ready  = !out_valid || ev.ready;
  assign take      = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.count  <= '0;
      st.alive  <= '1;
      urc_en    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        urc_en <= cfg.urc_enable;
      end
      if (take) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (ev.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= res;
    end
  end

  assign ev.valid       = out_valid;
  assign ev.event_code  = out_word.event_code;
  assign ev.urc_kind    = out_word.urc_kind;
  assign ev.line_length = out_word.line_length;

endmodule

[hw/rtl/atrlc_checker.sv]
// port-level assertions of the response line classifier, bound to the top level
module atrlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic [7:0] rx_byte,
  input logic       ev_valid,
  input logic       ev_ready,
  input logic [2:0] event_code,
  input logic [1:0] urc_kind,
  input logic [6:0] line_length
);

  a_kind_only_on_urc: assert property (@(posedge clk) disable iff (rst)
    ev_valid && urc_kind != atrlc_pkg::URC_NONE |-> event_code == atrlc_pkg::EV_URC)
    else $error("urc kind without urc event");

  a_prompt_no_length: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_code == atrlc_pkg::EV_PROMPT |-> line_length == '0)
    else $error("prompt with line length");

  a_plain_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready && rx_byte != atrlc_pkg::CHAR_NL &&
    rx_byte != atrlc_pkg::CHAR_PROMPT
    |=> ev_valid && event_code == atrlc_pkg::EV_NONE && line_length == '0)
    else $error("ordinary byte gave an event");

  a_ack_length: assert property (@(posedge clk) disable iff (rst)
    ev_valid && event_code != atrlc_pkg::EV_NONE &&
    event_code != atrlc_pkg::EV_PROMPT && event_code != atrlc_pkg::EV_URC
    |-> (event_code == atrlc_pkg::EV_OK && line_length == 7'd4) ||
        (event_code == atrlc_pkg::EV_ERROR && line_length == 7'd7) ||
        (event_code == atrlc_pkg::EV_BUSY && line_length == 7'd11) ||
        (event_code == atrlc_pkg::EV_READY && line_length == 7'd7))
    else $error("acknowledgement with wrong line length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_ready |=> ev_valid && $stable(event_code) && $stable(urc_kind) &&
    $stable(line_length))
    else $error("result word changed while stalled");

endmodule

bind at_response_line_classifier_unit atrlc_checker u_atrlc_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx.valid),
  .rx_ready    (rx.ready),
  .rx_byte     (rx.rx_byte),
  .ev_valid    (ev.valid),
  .ev_ready    (ev.ready),
  .event_code  (ev.event_code),
  .urc_kind    (ev.urc_kind),
  .line_length (ev.line_length)
);

[tb/at_response_line_classifier_unit_test.sv]
// self-checking testbench of the response line classifier: directed and random byte streams
module at_response_line_classifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         QUIET_LIMIT = 4000;
  localparam int         PHASE_BYTES = 400;
  localparam int         PRINT_CAP   = 60;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic [7:0] rx_data   = 8'h00;
  logic       ev_take   = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_urc   = 1'b0;

  atrlc_rx_if  rx_ch ();
  atrlc_ev_if  ev_ch ();
  atrlc_cfg_if cfg_ch ();

  assign rx_ch.valid       = rx_valid;
  assign rx_ch.rx_byte     = rx_data;
  assign ev_ch.ready       = ev_take;
  assign cfg_ch.valid      = cfg_valid;
  assign cfg_ch.urc_enable = cfg_urc;

  at_response_line_classifier_unit u_top (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .ev (ev_ch),
    .cfg(cfg_ch)
  );

  always #4 clk = ~clk;

  logic [7:0]          byte_backlog [$];
  atrlc_pkg::result_t  line_events [$];
  atrlc_pkg::result_t  oldest_event;
  int                  bytes_queued   = 0;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  mismatch_count = 0;
  int                  quiet_cycles   = 0;

  // line tracker state
  int                                 line_fill      = 0;
  logic [atrlc_pkg::NUM_PATTERNS-1:0] still_matching = '1;
  logic                               urc_reporting  = 1'b0;

  atrlc_pkg::event_t    ack_event [atrlc_pkg::NUM_EXACT] =
    '{atrlc_pkg::EV_OK, atrlc_pkg::EV_ERROR, atrlc_pkg::EV_BUSY, atrlc_pkg::EV_READY};
  atrlc_pkg::urc_kind_t urc_of [atrlc_pkg::NUM_PATTERNS-atrlc_pkg::NUM_EXACT] =
    '{atrlc_pkg::URC_CONN, atrlc_pkg::URC_DISCONN, atrlc_pkg::URC_WRITE};

  function automatic string line_pattern(int idx);
    case (idx)
      0:       return "OK\015\012";
      1:       return "ERROR\015\012";
      2:       return "busy p...\015\012";
      3:       return "ready\015\012";
      4:       return "+BLECONN:";
      5:       return "+BLEDISCONN:";
      default: return "+WRITE:";
    endcase
  endfunction

  function automatic atrlc_pkg::result_t classify_byte(logic [7:0] rx);
    atrlc_pkg::result_t res;
    string              pat;
    int                 i;
    res.event_code  = atrlc_pkg::EV_NONE;
    res.urc_kind    = atrlc_pkg::URC_NONE;
    res.line_length = '0;
    // bytes past the first LINE_CAPACITY - 1 of a line are dropped
    if (line_fill < atrlc_pkg::LINE_CAPACITY - 1) begin
      for (i = 0; i < atrlc_pkg::NUM_PATTERNS; i++) begin
        pat = line_pattern(i);
        if (still_matching[i]) begin
          if (line_fill < pat.len()) begin
            if (8'(pat[line_fill]) != rx) still_matching[i] = 1'b0;
          end else if (i < atrlc_pkg::NUM_EXACT) begin
            still_matching[i] = 1'b0;
          end
        end
      end
      line_fill++;
    end
    if (rx == atrlc_pkg::CHAR_PROMPT && line_fill == 1) begin
      res.event_code = atrlc_pkg::EV_PROMPT;
      line_fill      = 0;
      still_matching = '1;
    end else if (rx == atrlc_pkg::CHAR_NL) begin
      res.line_length = atrlc_pkg::LEN_W'((line_fill > atrlc_pkg::LEN_MAX) ?
                                         atrlc_pkg::LEN_MAX : line_fill);
      for (i = 0; i < atrlc_pkg::NUM_EXACT; i++) begin
        pat = line_pattern(i);
        if (res.event_code == atrlc_pkg::EV_NONE && still_matching[i] &&
            line_fill == pat.len())
          res.event_code = ack_event[i];
      end
      if (res.event_code == atrlc_pkg::EV_NONE && urc_reporting) begin
        for (i = atrlc_pkg::NUM_EXACT; i < atrlc_pkg::NUM_PATTERNS; i++) begin
          pat = line_pattern(i);
          if (res.event_code == atrlc_pkg::EV_NONE && still_matching[i] &&
              line_fill >= pat.len()) begin
            res.event_code = atrlc_pkg::EV_URC;
            res.urc_kind   = urc_of[i-atrlc_pkg::NUM_EXACT];
          end
        end
      end
      line_fill      = 0;
      still_matching = '1;
    end
    return res;
  endfunction

  function automatic void push_char(logic [7:0] c);
    byte_backlog.push_back(c);
    bytes_queued++;
  endfunction

  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(8'(s[i]));
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == atrlc_pkg::CHAR_NL);
    return c;
  endfunction

  // pattern text, one character replaced at bad_pos when it is in range
  function automatic void push_pattern(int idx, int bad_pos);
    string pat;
    int    i;
    pat = line_pattern(idx);
    for (i = 0; i < pat.len(); i++)
      push_char((i == bad_pos) ? filler_char() : 8'(pat[i]));
  endfunction

  function automatic void add_long_line();
    int n, i;
    n = $urandom_range(200, 110);
    if ($urandom_range(1) == 1)
      push_pattern($urandom_range(atrlc_pkg::NUM_PATTERNS-1, atrlc_pkg::NUM_EXACT), -1);
    for (i = 0; i < n; i++) push_char(filler_char());
    push_char(atrlc_pkg::CHAR_NL);
  endfunction

  function automatic void add_random_line();
    int    pick, idx, n, i;
    string pat;
    pick = $urandom_range(99);
    if (pick < 40) begin
      idx = $urandom_range(atrlc_pkg::NUM_EXACT-1);
      pat = line_pattern(idx);
      push_pattern(idx, ($urandom_range(3) == 0) ? $urandom_range(pat.len()-2) : -1);
    end else if (pick < 70) begin
      idx = $urandom_range(atrlc_pkg::NUM_PATTERNS-1, atrlc_pkg::NUM_EXACT);
      pat = line_pattern(idx);
      push_pattern(idx, ($urandom_range(4) == 0) ? $urandom_range(pat.len()-1) : -1);
      n = $urandom_range(12);
      for (i = 0; i < n; i++) push_char(filler_char());
      if ($urandom_range(1) == 1) push_char(CHAR_CR);
      push_char(atrlc_pkg::CHAR_NL);
    end else if (pick < 78) begin
      push_char(atrlc_pkg::CHAR_PROMPT);
    end else if (pick < 81) begin
      add_long_line();
    end else if (pick < 93) begin
      n = $urandom_range(16);
      for (i = 0; i < n; i++) push_char(filler_char());
      push_char(atrlc_pkg::CHAR_NL);
    end else begin
      // raw noise, newlines and prompts included
      n = $urandom_range(8, 1);
      for (i = 0; i < n; i++) push_char(8'($urandom_range(255)));
    end
  endfunction

  task automatic compare_field(string name, logic [6:0] want, logic [6:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || rx_valid || line_events.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_urc_enable(logic on);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_urc   <= on;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid     <= 1'b0;
    urc_reporting = on;
  endtask

  task automatic run_phase(logic urc_on, int idle_pct, int stall_pct);
    int start;
    settle();
    write_urc_enable(urc_on);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = bytes_queued;
    add_long_line();
    while (bytes_queued - start < PHASE_BYTES) add_random_line();
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (!rx_valid || rx_ch.ready) begin
      if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_valid <= 1'b1;
        rx_data  <= byte_backlog.pop_front();
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (rst) begin
      ev_take <= 1'b0;
    end else begin
      ev_take <= ($urandom_range(99) >= recv_stall_pct);
      if (ev_ch.valid && ev_take) begin
        if (line_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_CAP)
            $display("%0t: expected no word, got event %0d kind %0d length %0d", $time,
                     ev_ch.event_code, ev_ch.urc_kind, ev_ch.line_length);
        end else begin
          oldest_event = line_events.pop_front();
          compare_field("event_code", 7'(oldest_event.event_code), 7'(ev_ch.event_code));
          compare_field("urc_kind", 7'(oldest_event.urc_kind), 7'(ev_ch.urc_kind));
          compare_field("line_length", oldest_event.line_length, ev_ch.line_length);
        end
      end
      if (rx_valid && rx_ch.ready) line_events.push_back(classify_byte(rx_data));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (rx_valid && rx_ch.ready) || (ev_ch.valid && ev_take) ||
        (cfg_valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_urc_enable(1'b1);
    // acknowledgement, prompt, urc, late prompt character, extreme bytes, empty line
    push_text("OK\015\012");
    push_char(atrlc_pkg::CHAR_PROMPT);
    push_text("+WRITE:\012");
    push_text("x>\012");
    push_char(8'h00);
    push_char(8'hFF);
    push_char(atrlc_pkg::CHAR_NL);
    push_char(atrlc_pkg::CHAR_NL);
    run_phase(1'b1, 0, 0);
    run_phase(1'b0, 87, 0);
    run_phase(1'b1, 0, 87);
    run_phase(1'b0, 8, 8);
    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
